// ===== rtl/psarl_pkg.sv =====
// ----------------------------------------------------------------------------
// psarl_pkg
// Shared types and constants of the per-source alert rate limiter.
// ----------------------------------------------------------------------------
package psarl_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int SCAN_W = $clog2(TABLE_ENTRIES + 1);

	// field widths
	localparam int ADDR_W  = 32;
	localparam int KIND_W  = 8;
	localparam int KEY_W   = ADDR_W + KIND_W;
	localparam int TIME_W  = 64;
	localparam int COUNT_W = 32;
	localparam int REG_W   = 40;

	// register indexes and reset values
	localparam logic CFG_MIN_GAP = 1'b0;
	localparam logic CFG_WINDOW  = 1'b1;
	localparam logic [REG_W-1:0] MIN_GAP_DEFAULT = 40'd1000000000;
	localparam logic [REG_W-1:0] WINDOW_DEFAULT  = 40'd10000000000;

	// one table entry
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [TIME_W-1:0]  last_time;
		logic [COUNT_W-1:0] count;
	} entry_t;

	// table access from the sequencer
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_entry;
	} mem_req_t;

endpackage

// ===== rtl/psarl_table.sv =====
// ----------------------------------------------------------------------------
// psarl_table
// Entry store: one read and one write port, registered read data, and a
// valid flag per entry cleared by reset.
// ----------------------------------------------------------------------------
module psarl_table (
	input  logic              clk,
	input  logic              arst_n,
	input  psarl_pkg::mem_req_t req,
	output psarl_pkg::entry_t rd_entry,
	output logic              rd_valid
);

	psarl_pkg::entry_t mem_q [psarl_pkg::TABLE_ENTRIES];
	logic [psarl_pkg::TABLE_ENTRIES-1:0] valid_q;

	// entry storage, no reset
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_entry;
		end
		if (req.rd_en) begin
			rd_entry <= mem_q[req.rd_addr];
		end
	end

	// valid flags and registered valid of the read entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid <= valid_q[req.rd_addr];
			end
		end
	end

endmodule

// ===== rtl/per_source_alert_rate_limiter_core.sv =====
// Sequence: an accepted request scans the table entry by entry from entry 0;
// a hit goes on through the AGE and DECIDE states, a miss through MISS, and
// DONE then loads the result and raises out_valid. Throughput: one request at
// a time, one table read per scan cycle; set by the single table read port.
// Reset: asynchronous, clears all entry valid flags at once and loads the
// register defaults; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// per_source_alert_rate_limiter_core
// Minimum-interval rate limiter keyed by source address and event kind,
// with a sequential search over a fully associative table.
// ----------------------------------------------------------------------------
module per_source_alert_rate_limiter_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration writes
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [psarl_pkg::REG_W-1:0]        cfg_wdata,
	// request channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [psarl_pkg::ADDR_W-1:0]       source_addr,
	input  logic [psarl_pkg::KIND_W-1:0]       event_kind,
	input  logic [psarl_pkg::TIME_W-1:0]       now_ns,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               limited,
	output logic [psarl_pkg::COUNT_W-1:0]      alerts_in_window,
	output logic                               table_full
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_MISS   = 3'd2;
	localparam logic [2:0] ST_AGE    = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	localparam logic [psarl_pkg::SCAN_W-1:0] SCAN_END =
		psarl_pkg::SCAN_W'(psarl_pkg::TABLE_ENTRIES);
	localparam logic [psarl_pkg::COUNT_W-1:0] COUNT_ONE = psarl_pkg::COUNT_W'(1);

	logic [2:0]                         state_q;
	logic [psarl_pkg::REG_W-1:0]        min_gap_q;
	logic [psarl_pkg::REG_W-1:0]        window_q;
	logic [psarl_pkg::KEY_W-1:0]        key_q;
	logic [psarl_pkg::TIME_W-1:0]       now_q;
	logic [psarl_pkg::SCAN_W-1:0]       scan_q;
	logic                               pend_q;
	logic [psarl_pkg::IDX_W-1:0]        cmp_idx_q;
	logic                               free_found_q;
	logic [psarl_pkg::IDX_W-1:0]        free_idx_q;
	logic [psarl_pkg::IDX_W-1:0]        hit_idx_q;
	logic [psarl_pkg::TIME_W-1:0]       last_q;
	logic [psarl_pkg::COUNT_W-1:0]      count_q;
	logic [psarl_pkg::TIME_W-1:0]       age_q;
	logic                               res_limited_q;
	logic [psarl_pkg::COUNT_W-1:0]      res_count_q;
	logic                               res_full_q;

	psarl_pkg::mem_req_t                mem_req;
	psarl_pkg::entry_t                  rd_entry;
	logic                               rd_valid;
	logic                               issue;
	logic                               key_hit;
	logic [psarl_pkg::TIME_W-1:0]       window_ext;
	logic [psarl_pkg::TIME_W-1:0]       min_gap_ext;
	logic [psarl_pkg::COUNT_W-1:0]      count_inc;

	assign in_ready    = (state_q == ST_IDLE);
	assign issue       = (state_q == ST_SCAN) && (scan_q < SCAN_END);
	assign key_hit     = pend_q && rd_valid && (rd_entry.key == key_q);
	assign window_ext  = {{(psarl_pkg::TIME_W-psarl_pkg::REG_W){1'b0}}, window_q};
	assign min_gap_ext = {{(psarl_pkg::TIME_W-psarl_pkg::REG_W){1'b0}}, min_gap_q};
	assign count_inc   = (&count_q) ? count_q : count_q + COUNT_ONE;

	// table access
	always_comb begin
		mem_req                    = '0;
		mem_req.rd_en              = issue;
		mem_req.rd_addr            = scan_q[psarl_pkg::IDX_W-1:0];
		mem_req.wr_entry.key       = key_q;
		mem_req.wr_entry.last_time = now_q;
		mem_req.wr_entry.count     = COUNT_ONE;
		case (state_q)
			ST_MISS: begin
				mem_req.wr_en   = free_found_q;
				mem_req.wr_addr = free_idx_q;
			end
			ST_DECIDE: begin
				mem_req.wr_addr = hit_idx_q;
				if (age_q > window_ext) begin
					mem_req.wr_en = 1'b1;
				end else if (age_q >= min_gap_ext) begin
					mem_req.wr_en          = 1'b1;
					mem_req.wr_entry.count = count_inc;
				end
			end
			default: begin
			end
		endcase
	end

	psarl_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.rd_entry (rd_entry),
		.rd_valid (rd_valid)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= psarl_pkg::MIN_GAP_DEFAULT;
			window_q  <= psarl_pkg::WINDOW_DEFAULT;
		end else if (cfg_we) begin
			if (cfg_index == psarl_pkg::CFG_MIN_GAP) begin
				min_gap_q <= cfg_wdata;
			end else begin
				window_q <= cfg_wdata;
			end
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_q       <= '0;
			pend_q       <= 1'b0;
			free_found_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			// result valid: set when the result is loaded, cleared when taken
			if (state_q == ST_DONE && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q      <= ST_SCAN;
						scan_q       <= '0;
						pend_q       <= 1'b0;
						free_found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					pend_q <= issue;
					if (issue) begin
						scan_q <= scan_q + psarl_pkg::SCAN_W'(1);
					end
					if (key_hit) begin
						state_q <= ST_AGE;
					end else begin
						if (pend_q && !rd_valid) begin
							free_found_q <= 1'b1;
						end
						if (!pend_q && !issue) begin
							state_q <= ST_MISS;
						end
					end
				end
				ST_MISS: begin
					state_q <= ST_DONE;
				end
				ST_AGE: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request, search and result datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_q <= {source_addr, event_kind};
			now_q <= now_ns;
		end
		// index of the entry whose data arrives next cycle
		if (issue) begin
			cmp_idx_q <= scan_q[psarl_pkg::IDX_W-1:0];
		end
		// first free entry and the hit entry
		if (state_q == ST_SCAN && pend_q) begin
			if (!rd_valid && !free_found_q) begin
				free_idx_q <= cmp_idx_q;
			end
			if (key_hit) begin
				hit_idx_q <= cmp_idx_q;
				last_q    <= rd_entry.last_time;
				count_q   <= rd_entry.count;
			end
		end
		// age with wrap modulo 2^64
		if (state_q == ST_AGE) begin
			age_q <= now_q - last_q;
		end
		if (state_q == ST_MISS) begin
			res_limited_q <= 1'b0;
			res_count_q   <= free_found_q ? COUNT_ONE : '0;
			res_full_q    <= !free_found_q;
		end
		if (state_q == ST_DECIDE) begin
			res_full_q <= 1'b0;
			if (age_q > window_ext) begin
				res_limited_q <= 1'b0;
				res_count_q   <= COUNT_ONE;
			end else if (age_q < min_gap_ext) begin
				res_limited_q <= 1'b1;
				res_count_q   <= count_q;
			end else begin
				res_limited_q <= 1'b0;
				res_count_q   <= count_inc;
			end
		end
		// output register
		if (state_q == ST_DONE && (!out_valid || out_ready)) begin
			limited          <= res_limited_q;
			alerts_in_window <= res_count_q;
			table_full       <= res_full_q;
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-source alert rate limiter. A short table of
// directed requests covers the register extremes, the interval boundaries,
// time wrap and a window shorter than the gap. Random requests then run under
// several limit settings. Hot pairs are reused so that most requests hit,
// and the table fills up part way through. Every result is compared with its
// planned value or with an in-bench model of the table.
// ----------------------------------------------------------------------------
module tb;

	localparam int POOL_SIZE    = 72;
	localparam int HOT_KEYS     = 16;
	localparam int PHASE_ITEMS  = 190;
	localparam int CALM_ITEMS   = 120;
	localparam int STALL_LIMIT  = 10 * (psarl_pkg::TABLE_ENTRIES + 32);
	localparam logic [psarl_pkg::REG_W-1:0] REG_MAX = '1;

	typedef struct packed {
		logic                          limited;
		logic [psarl_pkg::COUNT_W-1:0] alerts;
		logic                          full;
	} alert_verdict_t;

	typedef enum logic {ROW_REQ, ROW_LIMITS} row_op_t;

	typedef struct {
		row_op_t                      op;
		logic [psarl_pkg::ADDR_W-1:0] addr;
		logic [psarl_pkg::KIND_W-1:0] kind;
		logic [psarl_pkg::TIME_W-1:0] now;
		logic [psarl_pkg::REG_W-1:0]  gap;
		logic [psarl_pkg::REG_W-1:0]  win;
		bit                           typed;
		alert_verdict_t               want;
	} plan_row_t;

	// block ports
	logic                          clk;
	logic                          arst_n           = 1'b0;
	logic                          cfg_we           = 1'b0;
	logic                          cfg_index        = psarl_pkg::CFG_MIN_GAP;
	logic [psarl_pkg::REG_W-1:0]   cfg_wdata        = '0;
	logic                          in_valid         = 1'b0;
	logic                          in_ready;
	logic [psarl_pkg::ADDR_W-1:0]  source_addr      = '0;
	logic [psarl_pkg::KIND_W-1:0]  event_kind       = '0;
	logic [psarl_pkg::TIME_W-1:0]  now_ns           = '0;
	logic                          out_valid;
	logic                          out_ready        = 1'b1;
	logic                          limited;
	logic [psarl_pkg::COUNT_W-1:0] alerts_in_window;
	logic                          table_full;

	// model of the table and limits
	logic [psarl_pkg::REG_W-1:0]   gap_reg    = psarl_pkg::MIN_GAP_DEFAULT;
	logic [psarl_pkg::REG_W-1:0]   window_reg = psarl_pkg::WINDOW_DEFAULT;
	bit                            lim_valid [psarl_pkg::TABLE_ENTRIES];
	logic [psarl_pkg::KEY_W-1:0]   lim_key   [psarl_pkg::TABLE_ENTRIES];
	logic [psarl_pkg::TIME_W-1:0]  lim_time  [psarl_pkg::TABLE_ENTRIES];
	logic [psarl_pkg::COUNT_W-1:0] lim_count [psarl_pkg::TABLE_ENTRIES];

	alert_verdict_t                pending_verdicts [$];
	plan_row_t                     plan [$];
	logic [psarl_pkg::KEY_W-1:0]   pool [POOL_SIZE];
	logic [psarl_pkg::TIME_W-1:0]  clock_ns     = '0;
	int                            mismatches   = 0;
	int                            stall_cycles = 0;
	int                            ready_hold   = 0;
	bit                            calm         = 1'b0;

	per_source_alert_rate_limiter_core DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.source_addr      (source_addr),
		.event_kind       (event_kind),
		.now_ns           (now_ns),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.limited          (limited),
		.alerts_in_window (alerts_in_window),
		.table_full       (table_full)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_error(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic logic [psarl_pkg::TIME_W-1:0] any_time();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [psarl_pkg::TIME_W-1:0] pick_between(
			input logic [psarl_pkg::TIME_W-1:0] lo,
			input logic [psarl_pkg::TIME_W-1:0] hi);
		return lo + any_time() % (hi - lo + 1);
	endfunction

	function automatic int find_entry(input logic [psarl_pkg::KEY_W-1:0] key);
		for (int i = 0; i < psarl_pkg::TABLE_ENTRIES; i++)
			if (lim_valid[i] && lim_key[i] == key)
				return i;
		return -1;
	endfunction

	// rate decision for one request, updating the table copy
	function automatic alert_verdict_t judge_alert(input logic [psarl_pkg::ADDR_W-1:0] addr,
			input logic [psarl_pkg::KIND_W-1:0] kind,
			input logic [psarl_pkg::TIME_W-1:0] now);
		logic [psarl_pkg::KEY_W-1:0]  key;
		logic [psarl_pkg::TIME_W-1:0] age;
		int                           hit;
		int                           slot;
		alert_verdict_t               v;
		key  = {addr, kind};
		hit  = find_entry(key);
		slot = -1;
		v    = '0;
		for (int i = psarl_pkg::TABLE_ENTRIES - 1; i >= 0; i--)
			if (!lim_valid[i])
				slot = i;
		if (hit < 0) begin
			// new pair: take the lowest free entry, or report a full table
			if (slot < 0) begin
				v.full = 1'b1;
			end else begin
				lim_valid[slot] = 1'b1;
				lim_key[slot]   = key;
				lim_time[slot]  = now;
				lim_count[slot] = 1;
				v.alerts        = 1;
			end
		end else begin
			// window test before the gap test
			age = now - lim_time[hit];
			if (age > window_reg) begin
				lim_time[hit]  = now;
				lim_count[hit] = 1;
			end else if (age < gap_reg) begin
				v.limited = 1'b1;
			end else begin
				lim_time[hit] = now;
				if (lim_count[hit] != '1)
					lim_count[hit]++;
			end
			v.alerts = lim_count[hit];
		end
		return v;
	endfunction

	// time for the next request, placed against the pair's stored time
	function automatic logic [psarl_pkg::TIME_W-1:0] pick_time(
			input logic [psarl_pkg::KEY_W-1:0] key);
		logic [psarl_pkg::TIME_W-1:0] base;
		logic [psarl_pkg::TIME_W-1:0] g;
		logic [psarl_pkg::TIME_W-1:0] w;
		logic [psarl_pkg::TIME_W-1:0] d;
		int                           hit;
		int                           sel;
		hit  = find_entry(key);
		base = (hit < 0) ? clock_ns : lim_time[hit];
		g    = gap_reg;
		w    = window_reg;
		sel  = $urandom_range(0, 99);
		if (sel < 30)
			d = (g == 0) ? '0 : pick_between(0, g - 1);
		else if (sel < 55)
			d = (g <= w) ? pick_between(g, w) : pick_between(0, w);
		else if (sel < 72)
			d = w + 1 + pick_between(0, w);
		else if (sel < 80)
			case ($urandom_range(0, 3))
				0: d = g;
				1: d = w;
				2: d = w + 1;
				default: d = (g == 0) ? '0 : g - 1;
			endcase
		else if (sel < 86)
			d = '0;
		else if (sel < 94)
			d = '0 - pick_between(1, w + 1);
		else
			d = any_time();
		return base + d;
	endfunction

	// drive one request and hold it until accepted
	task automatic send_alert(input logic [psarl_pkg::ADDR_W-1:0] addr,
			input logic [psarl_pkg::KIND_W-1:0] kind,
			input logic [psarl_pkg::TIME_W-1:0] now, input bit typed,
			input alert_verdict_t want);
		alert_verdict_t v;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		source_addr <= addr;
		event_kind  <= kind;
		now_ns      <= now;
		do @(posedge clk); while (!in_ready);
		v = judge_alert(addr, kind, now);
		clock_ns = now;
		pending_verdicts.push_back(typed ? want : v);
	endtask

	// register writes, only once every result is back
	task automatic load_limits(input logic [psarl_pkg::REG_W-1:0] gap,
			input logic [psarl_pkg::REG_W-1:0] win);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= psarl_pkg::CFG_MIN_GAP;
		cfg_wdata <= gap;
		@(posedge clk);
		cfg_index <= psarl_pkg::CFG_WINDOW;
		cfg_wdata <= win;
		@(posedge clk);
		cfg_we     <= 1'b0;
		gap_reg    = gap;
		window_reg = win;
	endtask

	task automatic plan_known(input logic [psarl_pkg::ADDR_W-1:0] addr,
			input logic [psarl_pkg::KIND_W-1:0] kind,
			input logic [psarl_pkg::TIME_W-1:0] now, input logic lim,
			input logic [psarl_pkg::COUNT_W-1:0] cnt, input logic full);
		plan_row_t r;
		r       = '{op: ROW_REQ, addr: addr, kind: kind, now: now, gap: '0, win: '0,
			typed: 1'b1, want: '0};
		r.want  = '{limited: lim, alerts: cnt, full: full};
		plan.push_back(r);
	endtask

	task automatic plan_req(input logic [psarl_pkg::ADDR_W-1:0] addr,
			input logic [psarl_pkg::KIND_W-1:0] kind,
			input logic [psarl_pkg::TIME_W-1:0] now);
		plan.push_back('{op: ROW_REQ, addr: addr, kind: kind, now: now, gap: '0, win: '0,
			typed: 1'b0, want: '0});
	endtask

	task automatic plan_limits(input logic [psarl_pkg::REG_W-1:0] gap,
			input logic [psarl_pkg::REG_W-1:0] win);
		plan.push_back('{op: ROW_LIMITS, addr: '0, kind: '0, now: '0, gap: gap, win: win,
			typed: 1'b0, want: '0});
	endtask

	// result ready: random stall bursts, none in the calm tail
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold--;
			if (ready_hold == 0)
				out_ready <= 1'b1;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			out_ready  <= 1'b0;
			ready_hold = $urandom_range(1, 11);
		end
	end

	// result check and watchdog
	always @(posedge clk) begin
		alert_verdict_t want;
		if (out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				report_error("result with no request outstanding");
			end else begin
				want = pending_verdicts.pop_front();
				if (limited !== want.limited)
					report_error($sformatf("limited got %0d, expected %0d",
						limited, want.limited));
				if (alerts_in_window !== want.alerts)
					report_error($sformatf("alerts_in_window got %0d, expected %0d",
						alerts_in_window, want.alerts));
				if (table_full !== want.full)
					report_error($sformatf("table_full got %0d, expected %0d",
						table_full, want.full));
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [psarl_pkg::REG_W-1:0] gaps [6];
		logic [psarl_pkg::REG_W-1:0] wins [6];
		logic [psarl_pkg::KEY_W-1:0] key;
		int                          sel;
		for (int i = 0; i < psarl_pkg::TABLE_ENTRIES; i++)
			lim_valid[i] = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = {$urandom, 8'($urandom_range(0, 255))};

		// directed table, reset limits first
		plan_known(32'h0, 8'h00, 64'd0, 1'b0, 1, 1'b0);
		plan_known(32'h0, 8'h00, 64'd999_999_999, 1'b1, 1, 1'b0);
		plan_known(32'h0, 8'h00, 64'd1_000_000_000, 1'b0, 2, 1'b0);
		plan_known(32'h0, 8'h00, 64'd11_000_000_000, 1'b0, 3, 1'b0);
		plan_known(32'h0, 8'h00, 64'd21_000_000_001, 1'b0, 1, 1'b0);
		plan_known(32'hFFFF_FFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1, 1'b0);
		plan_known(32'hFFFF_FFFF, 8'hFF, 64'd4, 1'b1, 1, 1'b0);
		plan_known(32'hFFFF_FFFF, 8'h00, 64'h8000_0000_0000_0000, 1'b0, 1, 1'b0);
		plan_known(32'h0, 8'hFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1, 1'b0);
		plan_known(32'hFFFF_FFFF, 8'hFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1, 1'b0);
		plan_known(32'h0, 8'h00, 64'd21_000_000_000, 1'b0, 1, 1'b0);
		plan_known(32'h0, 8'h00, 64'd22_000_000_000, 1'b0, 2, 1'b0);
		// gap longer than the window
		plan_limits(40'd5000, 40'd1000);
		plan_known(32'h1234_5678, 8'h5A, 64'd1_000_000, 1'b0, 1, 1'b0);
		plan_known(32'h1234_5678, 8'h5A, 64'd1_000_500, 1'b1, 1, 1'b0);
		plan_known(32'h1234_5678, 8'h5A, 64'd1_001_001, 1'b0, 1, 1'b0);
		plan_known(32'h1234_5678, 8'h5A, 64'd1_002_001, 1'b1, 1, 1'b0);
		// both limits at zero
		plan_limits('0, '0);
		plan_known(32'hA5A5_A5A5, 8'h3C, 64'd100, 1'b0, 1, 1'b0);
		plan_known(32'hA5A5_A5A5, 8'h3C, 64'd100, 1'b0, 2, 1'b0);
		plan_known(32'hA5A5_A5A5, 8'h3C, 64'd101, 1'b0, 1, 1'b0);
		plan_req(32'hFFFF_FFFF, 8'hFF, 64'h7FFF_FFFF_FFFF_FFFF);
		// both limits at maximum
		plan_limits(REG_MAX, REG_MAX);
		plan_known(32'h5A5A_5A5A, 8'hC3, 64'd0, 1'b0, 1, 1'b0);
		plan_known(32'h5A5A_5A5A, 8'hC3, 64'h0FF_FFFF_FFFF, 1'b0, 2, 1'b0);
		plan_known(32'h5A5A_5A5A, 8'hC3, 64'h1FF_FFFF_FFFD, 1'b1, 2, 1'b0);
		plan_req(32'h5A5A_5A5A, 8'hC3, 64'hDEAD_BEEF_0000);

		gaps = '{psarl_pkg::MIN_GAP_DEFAULT, 40'd100, '0, REG_MAX, 40'd5000,
			40'($urandom_range(0, 9999))};
		wins = '{psarl_pkg::WINDOW_DEFAULT, 40'd1000, '0, REG_MAX, 40'd1000,
			40'($urandom_range(0, 99999))};

		// reset
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].op == ROW_LIMITS)
				load_limits(plan[i].gap, plan[i].win);
			else
				send_alert(plan[i].addr, plan[i].kind, plan[i].now, plan[i].typed,
					plan[i].want);
		end

		// random requests: hot pairs, the whole pool, and odd stray pairs
		for (int p = 0; p < 6; p++) begin
			load_limits(gaps[p], wins[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				calm = (p == 5) && (n >= PHASE_ITEMS - CALM_ITEMS);
				sel  = $urandom_range(0, 99);
				if (sel < 70)
					key = pool[$urandom_range(0, HOT_KEYS - 1)];
				else if (sel < 95)
					key = pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					key = {$urandom, 8'($urandom_range(0, 255))};
				send_alert(key[psarl_pkg::KEY_W-1:psarl_pkg::KIND_W],
					key[psarl_pkg::KIND_W-1:0], pick_time(key), 1'b0, '0);
			end
		end

		// drain and settle
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (psarl_pkg::TABLE_ENTRIES + 16) @(posedge clk);
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
